@@ hw/rtl/zba_pkg.sv @@
// Shared types, constants and helper functions for the zone bitmap allocator.
// Used by every module of the block but zba_ram; depends on nothing else.

package zba_pkg;

	// Geometry of the usage bitmap. BITS_PER_MAP is a power of two and a multiple of 32.
	localparam int BITS_PER_MAP  = 8192;
	localparam int MAP_COUNT     = 8;
	localparam int WORD_BITS     = 32;
	localparam int WORDS_PER_MAP = BITS_PER_MAP / WORD_BITS;
	localparam int TOTAL_WORDS   = MAP_COUNT * WORDS_PER_MAP;

	localparam int BIT_IDX_W   = $clog2(WORD_BITS);
	localparam int MAP_SHIFT   = $clog2(BITS_PER_MAP);
	localparam int WPM_SHIFT   = MAP_SHIFT - BIT_IDX_W;
	localparam int WORD_ADDR_W = $clog2(TOTAL_WORDS);
	localparam int WORD_CNT_W  = $clog2(TOTAL_WORDS + 1);
	localparam int MAP_CNT_W   = $clog2(MAP_COUNT + 1);

	// Field and register widths.
	localparam int BLOCK_W    = 16;
	localparam int MAPS_REG_W = 4;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Zone arithmetic widths: a zone from a block number needs one bit more than the block.
	localparam int FOUND_W = WORD_ADDR_W + BIT_IDX_W;
	localparam int ZONE_W  = (FOUND_W > BLOCK_W + 1) ? FOUND_W : BLOCK_W + 1;
	localparam int NUM_W   = ((FOUND_W > BLOCK_W) ? FOUND_W : BLOCK_W) + 1;

	// Request queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_ZONE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE_COUNT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAPS_PRESENT    = 2'd2;

	// Register reset values.
	localparam logic [BLOCK_W-1:0]    FDZ_RESET  = 16'd0;
	localparam logic [BLOCK_W-1:0]    ZC_RESET   = 16'd65535;
	localparam logic [MAPS_REG_W-1:0] MAPS_RESET = 4'd8;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FREE_RANGE   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL         = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ALLOC_RANGE  = 3'd4;

	// Request action codes.
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Classified command kinds.
	typedef enum logic [1:0] {
		CMD_ALLOC,
		CMD_FREE,
		CMD_REJECT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [WORD_ADDR_W-1:0] word_addr;
		logic [BIT_IDX_W-1:0]   bit_idx;
	} cmd_t;

	// Live configuration seen by the back end.
	typedef struct packed {
		logic [BLOCK_W-1:0]    first_data_zone;
		logic [BLOCK_W-1:0]    zone_count;
		logic [WORD_CNT_W-1:0] words_end;
	} cfg_t;

	// Back end state machine.
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ALLOC_RD,
		BK_ALLOC_CHK,
		BK_ALLOC_FIN,
		BK_FREE_CHK,
		BK_RESP
	} bk_state_t;

	// Back end observation for the top-level checks.
	typedef struct packed {
		logic                  pop;
		logic [WORD_CNT_W-1:0] hint;
		logic [WORD_CNT_W-1:0] fill;
	} bk_stat_t;

	// Back end control outputs of one cycle.
	typedef struct packed {
		logic                   pop;
		logic                   ram_re;
		logic [WORD_ADDR_W-1:0] ram_raddr;
		logic                   ram_we;
		logic                   rsp_load;
	} bk_ctl_t;

	// Index of the lowest clear bit of a word; zero when the word is all ones.
	function automatic logic [BIT_IDX_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
		logic [BIT_IDX_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = BIT_IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

@@ hw/rtl/zone_bitmap_allocator.sv @@
// Top level of the zone bitmap allocator: front end, command queue and back end.
// Depends on zba_pkg, zba_front, zba_queue, zba_back and zba_ram.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------
//  request | req_valid/req_stall  | action, block_number
//  result  | rsp_valid/rsp_stall  | status, allocated_block
//  config  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// In the back end a free reads and checks its word and a rejected free goes straight
// to the result; an allocate reads bitmap words from the search hint up to the
// first word with a clear bit (usually one), each word taking one RAM read and
// one check. The front end takes a request into a two-entry queue when it has room.
// Reset clears the queue, the state machine, the fill count and the hint; the RAM
// needs no clearing pass, as words past the fill count read as their reset value.
// A stalled result holds in the output register while the back end works on.

module zone_bitmap_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic                             action,
	input  logic [zba_pkg::BLOCK_W-1:0]      block_number,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [zba_pkg::STATUS_W-1:0]     status,
	output logic [zba_pkg::BLOCK_W-1:0]      allocated_block,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [zba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [zba_pkg::CFG_DATA_W-1:0]   cfg_data
);

	zba_pkg::cmd_t     push_cmd;
	zba_pkg::cmd_t     head_cmd;
	zba_pkg::cfg_t     cfg;
	zba_pkg::bk_stat_t bk_stat;
	logic              q_push;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;

	zba_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.action       (action),
		.block_number (block_number),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (push_cmd),
		.cfg          (cfg)
	);

	zba_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (head_cmd),
		.empty    (q_empty)
	);

	zba_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.q_empty         (q_empty),
		.q_head          (head_cmd),
		.q_pop           (q_pop),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.status          (status),
		.allocated_block (allocated_block),
		.stat            (bk_stat)
	);

	// Every result that is not ok, a failed allocate or free, carries a zero block number.
	a_block_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != zba_pkg::ST_OK) |-> allocated_block == '0)
		else $error("nonzero block number on a non-ok result");

	// The search hint never runs past the written words.
	a_hint_within_fill: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.hint <= bk_stat.fill)
		else $error("search hint beyond fill count");

	// The back end only takes commands that are queued.
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.pop |-> !q_empty)
		else $error("command taken from an empty queue");

endmodule

@@ hw/rtl/zba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.

module zba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/zba_queue.sv @@
// Short command queue between the classifying front end and the back end.
// Depends on zba_pkg for the command type and queue depth.

module zba_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  zba_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output zba_pkg::cmd_t head,
	output logic          empty
);

	zba_pkg::cmd_t                  slot_q [zba_pkg::QUEUE_DEPTH];
	logic [zba_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [zba_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [zba_pkg::QCNT_W-1:0]     count_q;

	assign full  = (count_q == zba_pkg::QCNT_W'(zba_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == zba_pkg::QPTR_W'(zba_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == zba_pkg::QPTR_W'(zba_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ hw/rtl/zba_front.sv @@
// Front end: configuration registers, request acceptance and classification.
// Depends on zba_pkg; feeds zba_queue.

module zba_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic                             action,
	input  logic [zba_pkg::BLOCK_W-1:0]      block_number,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [zba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [zba_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             q_full,
	output logic                             q_push,
	output zba_pkg::cmd_t                    q_cmd,
	output zba_pkg::cfg_t                    cfg
);

	logic [zba_pkg::BLOCK_W-1:0]    fdz_q;
	logic [zba_pkg::BLOCK_W-1:0]    zc_q;
	logic [zba_pkg::MAPS_REG_W-1:0] maps_q;
	logic [zba_pkg::MAP_CNT_W-1:0]  maps_en;
	logic [zba_pkg::ZONE_W-1:0]     zone;
	logic                           out_of_zone;
	logic                           no_map;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fdz_q  <= zba_pkg::FDZ_RESET;
			zc_q   <= zba_pkg::ZC_RESET;
			maps_q <= zba_pkg::MAPS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				zba_pkg::CFG_FIRST_DATA_ZONE: begin
					fdz_q <= cfg_data;
				end
				zba_pkg::CFG_ZONE_COUNT: begin
					zc_q <= cfg_data;
				end
				zba_pkg::CFG_MAPS_PRESENT: begin
					maps_q <= cfg_data[zba_pkg::MAPS_REG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Number of maps in use, capped at the maps that exist.
	always_comb begin
		if (32'(maps_q) > zba_pkg::MAP_COUNT) begin
			maps_en = zba_pkg::MAP_CNT_W'(zba_pkg::MAP_COUNT);
		end else begin
			maps_en = zba_pkg::MAP_CNT_W'(maps_q);
		end
	end

	assign cfg.first_data_zone = fdz_q;
	assign cfg.zone_count      = zc_q;
	assign cfg.words_end       = zba_pkg::WORD_CNT_W'(maps_en) << zba_pkg::WPM_SHIFT;

	// Free requests: range checks and mapping of the block to a word and bit.
	assign zone        = zba_pkg::ZONE_W'(block_number) - zba_pkg::ZONE_W'(fdz_q) +
		zba_pkg::ZONE_W'(1);
	assign out_of_zone = (block_number < fdz_q) || (block_number >= zc_q);
	assign no_map      = (32'(zone >> zba_pkg::MAP_SHIFT) >= 32'(maps_en));

	always_comb begin
		q_cmd.word_addr = zone[zba_pkg::FOUND_W-1:zba_pkg::BIT_IDX_W];
		q_cmd.bit_idx   = zone[zba_pkg::BIT_IDX_W-1:0];
		if (action == zba_pkg::ACT_ALLOC) begin
			q_cmd.kind = zba_pkg::CMD_ALLOC;
		end else if (out_of_zone || no_map) begin
			q_cmd.kind = zba_pkg::CMD_REJECT;
		end else begin
			q_cmd.kind = zba_pkg::CMD_FREE;
		end
	end

	// A request is taken whenever the queue has room.
	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full;

endmodule

@@ hw/rtl/zba_back.sv @@
// Back end: executes allocate and free commands against the bitmap RAM.
// Depends on zba_pkg and zba_ram; takes commands from zba_queue.

module zba_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  zba_pkg::cfg_t                  cfg,
	input  logic                           q_empty,
	input  zba_pkg::cmd_t                  q_head,
	output logic                           q_pop,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [zba_pkg::STATUS_W-1:0]   status,
	output logic [zba_pkg::BLOCK_W-1:0]    allocated_block,
	output zba_pkg::bk_stat_t              stat
);

	zba_pkg::bk_state_t                state_q;
	zba_pkg::bk_state_t                state_d;
	zba_pkg::bk_ctl_t                  ctl;

	// Words below fill_q have been written; all words below hint_q are full.
	logic [zba_pkg::WORD_CNT_W-1:0]    fill_q;
	logic [zba_pkg::WORD_CNT_W-1:0]    hint_q;
	logic [zba_pkg::WORD_CNT_W-1:0]    scan_q;
	logic [zba_pkg::WORD_ADDR_W-1:0]   cur_addr_q;
	logic [zba_pkg::BIT_IDX_W-1:0]     bit_q;
	logic [zba_pkg::STATUS_W-1:0]      res_status_q;
	logic [zba_pkg::BLOCK_W-1:0]       res_block_q;
	logic                              rsp_valid_q;
	logic [zba_pkg::STATUS_W-1:0]      rsp_status_q;
	logic [zba_pkg::BLOCK_W-1:0]       rsp_block_q;

	logic [zba_pkg::WORD_BITS-1:0]     ram_rdata;
	logic [zba_pkg::WORD_BITS-1:0]     ram_wdata;
	logic [zba_pkg::WORD_BITS-1:0]     rd_word;
	logic [zba_pkg::BIT_IDX_W-1:0]     clr_idx;
	logic [zba_pkg::WORD_BITS-1:0]     set_word;
	logic [zba_pkg::WORD_BITS-1:0]     cleared_word;
	logic                              bit_was_set;
	logic                              scan_done;
	logic [zba_pkg::WORD_CNT_W-1:0]    cur_next;
	logic [zba_pkg::NUM_W-1:0]         alloc_num;
	logic                              alloc_bad;

	zba_ram #(
		.WIDTH(zba_pkg::WORD_BITS),
		.DEPTH(zba_pkg::TOTAL_WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (ctl.ram_we),
		.waddr (cur_addr_q),
		.wdata (ram_wdata),
		.re    (ctl.ram_re),
		.raddr (ctl.ram_raddr),
		.rdata (ram_rdata)
	);

	// Words never written read as their reset value; word 0 keeps the reserved bit.
	always_comb begin
		if (zba_pkg::WORD_CNT_W'(cur_addr_q) < fill_q) begin
			rd_word = ram_rdata;
		end else if (cur_addr_q == '0) begin
			rd_word = zba_pkg::WORD_BITS'(1);
		end else begin
			rd_word = '0;
		end
	end

	// Word updates for allocate and free.
	assign clr_idx      = zba_pkg::lowest_clear(rd_word);
	assign set_word     = rd_word | (zba_pkg::WORD_BITS'(1) << clr_idx);
	assign cleared_word = rd_word & ~(zba_pkg::WORD_BITS'(1) << bit_q);
	assign bit_was_set  = rd_word[bit_q];
	assign ram_wdata    = (state_q == zba_pkg::BK_FREE_CHK) ? cleared_word : set_word;
	assign scan_done    = (scan_q >= cfg.words_end);
	assign cur_next     = zba_pkg::WORD_CNT_W'(cur_addr_q) + 1'b1;

	// Block number of the found bit: zone + first_data_zone - 1, checked against the range.
	assign alloc_num = zba_pkg::NUM_W'({cur_addr_q, bit_q}) +
		zba_pkg::NUM_W'(cfg.first_data_zone);
	assign alloc_bad = (alloc_num == '0) || (alloc_num > zba_pkg::NUM_W'(cfg.zone_count));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			zba_pkg::BK_IDLE: begin
				if (!q_empty) begin
					case (q_head.kind)
						zba_pkg::CMD_ALLOC: state_d = zba_pkg::BK_ALLOC_RD;
						zba_pkg::CMD_FREE:  state_d = zba_pkg::BK_FREE_CHK;
						default:            state_d = zba_pkg::BK_RESP;
					endcase
				end
			end
			zba_pkg::BK_ALLOC_RD: begin
				state_d = scan_done ? zba_pkg::BK_RESP : zba_pkg::BK_ALLOC_CHK;
			end
			zba_pkg::BK_ALLOC_CHK: begin
				state_d = (&rd_word) ? zba_pkg::BK_ALLOC_RD : zba_pkg::BK_ALLOC_FIN;
			end
			zba_pkg::BK_ALLOC_FIN: begin
				state_d = zba_pkg::BK_RESP;
			end
			zba_pkg::BK_FREE_CHK: begin
				state_d = zba_pkg::BK_RESP;
			end
			zba_pkg::BK_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = zba_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = zba_pkg::BK_IDLE;
			end
		endcase
	end

	// Control outputs of the current state.
	always_comb begin
		ctl = '0;
		case (state_q)
			zba_pkg::BK_IDLE: begin
				ctl.pop       = !q_empty;
				ctl.ram_re    = !q_empty && (q_head.kind == zba_pkg::CMD_FREE);
				ctl.ram_raddr = q_head.word_addr;
			end
			zba_pkg::BK_ALLOC_RD: begin
				ctl.ram_re    = !scan_done;
				ctl.ram_raddr = scan_q[zba_pkg::WORD_ADDR_W-1:0];
			end
			zba_pkg::BK_ALLOC_CHK: begin
				ctl.ram_we = !(&rd_word);
			end
			zba_pkg::BK_FREE_CHK: begin
				ctl.ram_we = bit_was_set;
			end
			zba_pkg::BK_RESP: begin
				ctl.rsp_load = !rsp_valid_q || !rsp_stall;
			end
			default: begin
			end
		endcase
	end

	// Control registers: state, fill count, search hint and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= zba_pkg::BK_IDLE;
			fill_q      <= '0;
			hint_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.ram_we && (cur_next > fill_q)) begin
				fill_q <= cur_next;
			end
			if (ctl.ram_we && (state_q == zba_pkg::BK_ALLOC_CHK)) begin
				hint_q <= (&set_word) ? cur_next : zba_pkg::WORD_CNT_W'(cur_addr_q);
			end else if (ctl.ram_we && (zba_pkg::WORD_CNT_W'(cur_addr_q) < hint_q)) begin
				hint_q <= zba_pkg::WORD_CNT_W'(cur_addr_q);
			end
			if (ctl.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and the result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			zba_pkg::BK_IDLE: begin
				scan_q       <= hint_q;
				cur_addr_q   <= q_head.word_addr;
				bit_q        <= q_head.bit_idx;
				res_status_q <= zba_pkg::ST_FREE_RANGE;
				res_block_q  <= '0;
			end
			zba_pkg::BK_ALLOC_RD: begin
				cur_addr_q   <= scan_q[zba_pkg::WORD_ADDR_W-1:0];
				res_status_q <= zba_pkg::ST_FULL;
			end
			zba_pkg::BK_ALLOC_CHK: begin
				scan_q <= scan_q + 1'b1;
				bit_q  <= clr_idx;
			end
			zba_pkg::BK_ALLOC_FIN: begin
				res_status_q <= alloc_bad ? zba_pkg::ST_ALLOC_RANGE : zba_pkg::ST_OK;
				res_block_q  <= alloc_bad ? '0 : zba_pkg::BLOCK_W'(alloc_num - 1'b1);
			end
			zba_pkg::BK_FREE_CHK: begin
				res_status_q <= bit_was_set ? zba_pkg::ST_OK : zba_pkg::ST_ALREADY_FREE;
			end
			default: begin
			end
		endcase
		if (ctl.rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_block_q  <= res_block_q;
		end
	end

	assign q_pop           = ctl.pop;
	assign rsp_valid       = rsp_valid_q;
	assign status          = rsp_status_q;
	assign allocated_block = rsp_block_q;

	assign stat.pop  = ctl.pop;
	assign stat.hint = hint_q;
	assign stat.fill = fill_q;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for zone_bitmap_allocator: a directed table, then random phases.
// Depends on zba_pkg and the RTL; keeps its own bitmap and register copies to predict results.

module testbench;
	import zba_pkg::*;

	localparam int NUM_PHASES     = 6;
	localparam int PHASE_REQUESTS = 240;
	localparam int QUIET_LIMIT    = 50000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct packed {
		logic [STATUS_W-1:0] code;
		logic [BLOCK_W-1:0]  number;
	} zone_result_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_FIXED,
		ROW_PREDICTED
	} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic                  op;
		logic [BLOCK_W-1:0]    value;
		zone_result_t          outcome;
	} stim_row_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_SOME,
		STALL_HEAVY
	} stall_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	logic                  action = ACT_ALLOC;
	logic [BLOCK_W-1:0]    block_number = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [BLOCK_W-1:0]    allocated_block;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_FIRST_DATA_ZONE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor state: usage bitmap words and the register copies.
	logic [WORD_BITS-1:0]  zone_words [TOTAL_WORDS];
	logic [BLOCK_W-1:0]    shadow_fdz;
	logic [BLOCK_W-1:0]    shadow_zc;
	logic [MAPS_REG_W-1:0] shadow_maps;

	zone_result_t zone_outcomes_due[$];
	int unsigned  live_zones[$];
	stim_row_t    directed_rows[$];

	int          mismatch_count = 0;
	int          quiet_cycles = 0;
	int          burst_left = 0;
	int          stall_mode_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	zone_bitmap_allocator i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.action          (action),
		.block_number    (block_number),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.status          (status),
		.allocated_block (allocated_block),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predict one request: first-fit allocate over the enabled maps, or a checked free.
	// A bit set by an allocate is reported through set_zone, otherwise set_zone is zero.
	task automatic predict_zone_request(input logic op, input logic [BLOCK_W-1:0] blk,
			output zone_result_t res, output int unsigned set_zone);
		int unsigned maps_on;
		int unsigned word_end;
		int unsigned found_zone;
		int unsigned zone;
		bit          found;
		longint      num;
		res.code = ST_OK;
		res.number = '0;
		set_zone = 0;
		found = 1'b0;
		found_zone = 0;
		maps_on = (shadow_maps > MAP_COUNT) ? MAP_COUNT : shadow_maps;
		if (op == ACT_ALLOC) begin
			// Maps are contiguous, so the lowest clear bit below the enabled end is first fit.
			word_end = maps_on * WORDS_PER_MAP;
			for (int w = 0; w < word_end && !found; w++) begin
				if (zone_words[w] != '1) begin
					for (int b = 0; b < WORD_BITS && !found; b++) begin
						if (!zone_words[w][b]) begin
							found = 1'b1;
							found_zone = w * WORD_BITS + b;
						end
					end
				end
			end
			if (!found) begin
				res.code = ST_FULL;
			end else begin
				// The bit stays set even when the number turns out out of range.
				zone_words[found_zone / WORD_BITS][found_zone % WORD_BITS] = 1'b1;
				set_zone = found_zone;
				num = longint'(found_zone) + longint'(shadow_fdz) - 1;
				if (num < 0 || num >= longint'(shadow_zc)) begin
					res.code = ST_ALLOC_RANGE;
				end else begin
					res.number = BLOCK_W'(num);
				end
			end
		end else if (blk < shadow_fdz || blk >= shadow_zc) begin
			res.code = ST_FREE_RANGE;
		end else begin
			zone = int'(blk) - int'(shadow_fdz) + 1;
			if (zone / BITS_PER_MAP >= maps_on) begin
				res.code = ST_FREE_RANGE;
			end else begin
				res.code = zone_words[zone / WORD_BITS][zone % WORD_BITS] ?
					ST_OK : ST_ALREADY_FREE;
				zone_words[zone / WORD_BITS][zone % WORD_BITS] = 1'b0;
			end
		end
	endtask

	// Send one request in the current burst, opening a random gap when the burst runs out.
	task automatic send_request(input logic op, input logic [BLOCK_W-1:0] blk,
			input bit use_fixed, input zone_result_t fixed_res);
		zone_result_t predicted;
		int unsigned  set_zone;
		int           gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 30);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		action <= op;
		block_number <= blk;
		do @(posedge clk); while (req_stall);
		// The request was taken at this edge.
		predict_zone_request(op, blk, predicted, set_zone);
		zone_outcomes_due.push_back(use_fixed ? fixed_res : predicted);
		if (set_zone != 0) begin
			live_zones.push_back(set_zone);
		end
	endtask

	// Write one register once every outstanding result has been collected.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		req_valid <= 1'b0;
		do @(negedge clk); while (zone_outcomes_due.size() != 0);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FIRST_DATA_ZONE: shadow_fdz = val[BLOCK_W-1:0];
			CFG_ZONE_COUNT:      shadow_zc = val[BLOCK_W-1:0];
			CFG_MAPS_PRESENT:    shadow_maps = val[MAPS_REG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [BLOCK_W-1:0] val);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.reg_idx = idx;
		row.op = ACT_ALLOC;
		row.value = val;
		row.outcome = '0;
		directed_rows.push_back(row);
	endtask

	task automatic add_req(input row_kind_t kind, input logic op, input logic [BLOCK_W-1:0] val,
			input logic [STATUS_W-1:0] code, input logic [BLOCK_W-1:0] number);
		stim_row_t row;
		row.kind = kind;
		row.reg_idx = CFG_FIRST_DATA_ZONE;
		row.op = op;
		row.value = val;
		row.outcome.code = code;
		row.outcome.number = number;
		directed_rows.push_back(row);
	endtask

	// Receiver: stall behavior switches at random between no, some and heavy stalling.
	always @(posedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 2));
			stall_mode_left = $urandom_range(20, 200);
		end else begin
			stall_mode_left--;
		end
		case (stall_mode)
			STALL_NONE:  rsp_stall <= 1'b0;
			STALL_SOME:  rsp_stall <= ($urandom_range(0, 99) < 30);
			default:     rsp_stall <= ($urandom_range(0, 99) < 75);
		endcase
	end

	// Result checker: every taken result is matched against the oldest expectation.
	always @(posedge clk) begin
		zone_result_t due;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (zone_outcomes_due.size() == 0) begin
				$error("unexpected result: status %0d, allocated_block %0d",
					status, allocated_block);
				mismatch_count++;
			end else begin
				due = zone_outcomes_due.pop_front();
				if (status !== due.code) begin
					$error("status: expected %0d, actual %0d", due.code, status);
					mismatch_count++;
				end
				if (allocated_block !== due.number) begin
					$error("allocated_block: expected %0d, actual %0d",
						due.number, allocated_block);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: too long without any handshake on any channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		stim_row_t              row;
		int                     pick;
		int                     k;
		int unsigned            zone;
		int                     zc_wide;
		logic [BLOCK_W-1:0]     fdz_val;
		logic [BLOCK_W-1:0]     zc_val;
		logic [MAPS_REG_W-1:0]  maps_val;
		logic [CFG_DATA_W-1:0]  maps_word;
		logic [11:0]            junk;

		// Predictor reset: bit 0 of map 0 is reserved.
		for (int w = 0; w < TOTAL_WORDS; w++) begin
			zone_words[w] = '0;
		end
		zone_words[0][0] = 1'b1;
		shadow_fdz = FDZ_RESET;
		shadow_zc = ZC_RESET;
		shadow_maps = MAPS_RESET;

		// Directed table: first fit after reset, double free, the range checks,
		// no map enabled, a free into a missing map, too many maps, and the
		// extremes of both zone registers.
		add_req(ROW_FIXED, ACT_ALLOC, 16'hFFFF, ST_OK, 16'd0);
		add_req(ROW_FIXED, ACT_ALLOC, 16'h0000, ST_OK, 16'd1);
		add_req(ROW_FIXED, ACT_FREE, 16'd0, ST_OK, 16'd0);
		add_req(ROW_FIXED, ACT_FREE, 16'd0, ST_ALREADY_FREE, 16'd0);
		add_req(ROW_FIXED, ACT_ALLOC, 16'h5A5A, ST_OK, 16'd0);
		add_req(ROW_FIXED, ACT_FREE, 16'hFFFF, ST_FREE_RANGE, 16'd0);
		add_req(ROW_FIXED, ACT_FREE, 16'd40000, ST_ALREADY_FREE, 16'd0);
		add_cfg(CFG_MAPS_PRESENT, 16'h0000);
		add_req(ROW_FIXED, ACT_ALLOC, 16'hFFFF, ST_FULL, 16'd0);
		add_req(ROW_FIXED, ACT_FREE, 16'd5, ST_FREE_RANGE, 16'd0);
		add_cfg(CFG_MAPS_PRESENT, 16'hFFF1);
		add_req(ROW_FIXED, ACT_FREE, 16'd9000, ST_FREE_RANGE, 16'd0);
		add_cfg(CFG_MAPS_PRESENT, 16'h000F);
		add_req(ROW_FIXED, ACT_FREE, 16'd65534, ST_ALREADY_FREE, 16'd0);
		add_cfg(CFG_ZONE_COUNT, 16'd0);
		add_req(ROW_FIXED, ACT_ALLOC, 16'h0000, ST_ALLOC_RANGE, 16'd0);
		add_req(ROW_FIXED, ACT_FREE, 16'd0, ST_FREE_RANGE, 16'd0);
		add_cfg(CFG_ZONE_COUNT, 16'hFFFF);
		add_cfg(CFG_FIRST_DATA_ZONE, 16'hFFFF);
		add_req(ROW_FIXED, ACT_ALLOC, 16'h0000, ST_ALLOC_RANGE, 16'd0);
		add_req(ROW_FIXED, ACT_FREE, 16'hFFFF, ST_FREE_RANGE, 16'd0);
		add_req(ROW_FIXED, ACT_FREE, 16'd0, ST_FREE_RANGE, 16'd0);
		add_cfg(CFG_FIRST_DATA_ZONE, 16'd100);
		add_cfg(CFG_ZONE_COUNT, 16'd200);
		add_req(ROW_PREDICTED, ACT_ALLOC, 16'h0000, ST_OK, 16'd0);
		add_req(ROW_PREDICTED, ACT_FREE, 16'd104, ST_OK, 16'd0);
		add_req(ROW_FIXED, ACT_FREE, 16'd99, ST_FREE_RANGE, 16'd0);
		add_req(ROW_PREDICTED, ACT_FREE, 16'd199, ST_OK, 16'd0);
		add_req(ROW_FIXED, ACT_FREE, 16'd200, ST_FREE_RANGE, 16'd0);
		add_req(ROW_PREDICTED, ACT_ALLOC, 16'h0000, ST_OK, 16'd0);

		// Reset is applied once, at the start.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_CFG) begin
				write_register(row.reg_idx, row.value);
			end else begin
				send_request(row.op, row.value, row.kind == ROW_FIXED, row.outcome);
			end
		end

		// Random phases: each one reprograms all registers, then runs a request mix.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			junk = 12'($urandom);
			if (phase == 0) begin
				fdz_val = 16'd0;
				zc_val = 16'hFFFF;
				maps_val = 4'd8;
			end else if (phase == 1) begin
				fdz_val = 16'($urandom_range(1, 64));
				zc_val = 16'hFFFF;
				maps_val = 4'd15;
			end else begin
				pick = $urandom_range(0, 99);
				fdz_val = (pick < 70) ? 16'($urandom_range(0, 64)) :
					(pick < 85) ? 16'hFFFF : 16'($urandom);
				pick = $urandom_range(0, 99);
				zc_wide = int'(fdz_val) + $urandom_range(0, 1500);
				zc_val = (pick < 60) ? 16'hFFFF :
					(pick < 85) ? ((zc_wide > 65535) ? 16'hFFFF : 16'(zc_wide)) :
					16'($urandom);
				pick = $urandom_range(0, 99);
				maps_val = (pick < 70) ? 4'($urandom_range(1, 8)) :
					(pick < 80) ? 4'd0 : 4'($urandom_range(9, 15));
			end
			maps_word = {junk, maps_val};
			write_register(CFG_FIRST_DATA_ZONE, fdz_val);
			write_register(CFG_ZONE_COUNT, zc_val);
			write_register(CFG_MAPS_PRESENT, maps_word);

			// Mostly allocates and frees of live blocks, with some stray frees.
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					send_request(ACT_ALLOC, 16'($urandom), 1'b0, '0);
				end else if (pick < 80 && live_zones.size() > 0) begin
					k = $urandom_range(0, live_zones.size() - 1);
					zone = live_zones[k];
					live_zones.delete(k);
					send_request(ACT_FREE, BLOCK_W'(zone + shadow_fdz - 1), 1'b0, '0);
				end else if (pick < 92) begin
					send_request(ACT_FREE, BLOCK_W'(shadow_fdz + $urandom_range(0, 2000)),
						1'b0, '0);
				end else begin
					send_request(ACT_FREE, 16'($urandom), 1'b0, '0);
				end
			end
		end

		// Drain, then allow a short window for any stray result.
		req_valid <= 1'b0;
		do @(negedge clk); while (zone_outcomes_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && zone_outcomes_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
